@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication, held off during reset
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// next-cycle implication, held off during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ design/sha1_pkg.sv @@
// ----------------------------------------------------------------------------
// sha1_pkg
// Widths, constants and round functions of the SHA-1 engine.
// ----------------------------------------------------------------------------
package sha1_pkg;

    localparam int COUNT_WIDTH = 61;   // message byte counter width, up to 61
    localparam int WORD_W      = 32;
    localparam int BYTE_W      = 8;
    localparam int NUM_WORDS   = 5;
    localparam int IDX_W       = 3;
    localparam int LEN_W       = 64;
    localparam int BLOCK_W     = 512;
    localparam int ROUND_W     = 7;
    localparam int NUM_ROUNDS  = 80;

    // input transaction opcodes
    typedef enum logic {
        OP_ABSORB = 1'b0,
        OP_FINISH = 1'b1
    } t_op;

    localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(NUM_ROUNDS - 1);
    localparam logic [IDX_W-1:0]   LAST_IDX   = IDX_W'(NUM_WORDS - 1);

    localparam logic [5:0] OFS_LAST = 6'd63;   // last byte of a block
    localparam logic [5:0] OFS_LEN  = 6'd56;   // start of the length field

    localparam logic [BYTE_W-1:0] PAD_MARK = 8'h80;
    localparam logic [BYTE_W-1:0] PAD_ZERO = 8'h00;

    localparam logic [WORD_W-1:0] IV [NUM_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [WORD_W-1:0] K0 = 32'h5A827999;
    localparam logic [WORD_W-1:0] K1 = 32'h6ED9EBA1;
    localparam logic [WORD_W-1:0] K2 = 32'h8F1BBCDC;
    localparam logic [WORD_W-1:0] K3 = 32'hCA62C1D6;

    function automatic logic [WORD_W-1:0] round_k(input logic [ROUND_W-1:0] t);
        logic [WORD_W-1:0] k;
        priority if (t < ROUND_W'(20)) k = K0;
        else if (t < ROUND_W'(40))     k = K1;
        else if (t < ROUND_W'(60))     k = K2;
        else                           k = K3;
        return k;
    endfunction

    function automatic logic [WORD_W-1:0] round_f(
        input logic [ROUND_W-1:0] t,
        input logic [WORD_W-1:0]  b,
        input logic [WORD_W-1:0]  c,
        input logic [WORD_W-1:0]  d
    );
        logic [WORD_W-1:0] f;
        priority if (t < ROUND_W'(20)) f = (b & c) | (~b & d);
        else if (t < ROUND_W'(40))     f = b ^ c ^ d;
        else if (t < ROUND_W'(60))     f = (b & c) | (b & d) | (c & d);
        else                           f = b ^ c ^ d;
        return f;
    endfunction

endpackage

@@ design/sha1_if.sv @@
// ----------------------------------------------------------------------------
// sha1_if
// Valid/ready channels of the SHA-1 engine: input items and digest words.
// ----------------------------------------------------------------------------
interface sha1_in_if;
    import sha1_pkg::*;

    logic              valid;
    logic              ready;
    logic              op;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output op, output data_byte, input ready);
    modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface sha1_out_if;
    import sha1_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] digest_word;
    logic [IDX_W-1:0]  word_index;
    logic              last;

    modport source (output valid, output digest_word, output word_index, output last,
                    input ready);
    modport sink   (input valid, input digest_word, input word_index, input last,
                    output ready);
endinterface

@@ design/sha1_hash_engine.sv @@
// ----------------------------------------------------------------------------
// sha1_hash_engine
// SHA-1 (160-bit digest) over a byte stream with one shared round unit.
// ----------------------------------------------------------------------------
// Each input transaction either absorbs one message byte (op = 0) or finishes
// the message (op = 1). Bytes shift into a 512-bit window that doubles as the
// message schedule. The byte that fills a block starts a busy phase: 80
// passes through the single round unit (one round per cycle), then a fold
// of the working words into the chain. Finish pads one byte per cycle while
// no block is being compressed: 0x80, zeros up to byte 56 of the block
// (through a further block when fewer than 8 bytes remain), a switch step at
// the length boundary, then 8 bytes of bit length; every block completed on
// the way is compressed and folded the same way. The five digest words then
// leave as five output transactions, word 0 first, the last one flagged;
// after the fifth the chain and the byte count return to their initial
// values. The input is not ready while a block is compressed, padded or the
// digest is emitted. The byte count is COUNT_WIDTH bits and wraps; the
// length field is the count times eight in 64 bits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sha1_hash_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sha1_in_if.sink     i_in,
    sha1_out_if.source  o_out
);
    import sha1_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,    // accepting bytes
        ST_PAD,     // zero padding
        ST_LEN,     // length bytes
        ST_ROUND,   // compression rounds
        ST_FOLD,    // chain update
        ST_OUT      // digest words out
    } t_state;

    t_state                 r_state;
    logic [COUNT_WIDTH-1:0] r_count;
    logic [BLOCK_W-1:0]     r_win;         // block buffer / schedule window
    logic [LEN_W-1:0]       r_len;         // length field, shifted out MSB first
    logic [ROUND_W-1:0]     r_round;
    logic [IDX_W-1:0]       r_idx;
    logic                   r_finishing;   // padding in progress
    logic                   r_final;       // current block is the last one
    logic [WORD_W-1:0]      r_chain [NUM_WORDS];
    logic [WORD_W-1:0]      r_a, r_b, r_c, r_d, r_e;

    logic [5:0]             ofs;
    logic                   in_fire;
    logic                   out_fire;
    logic [LEN_W-1:0]       bit_len;
    logic [WORD_W-1:0]      w_cur;
    logic [WORD_W-1:0]      w_mix;
    logic [WORD_W-1:0]      n_a;
    logic [WORD_W-1:0]      n_sched;

    assign ofs      = r_count[5:0];
    assign in_fire  = i_in.valid && i_in.ready;
    assign out_fire = o_out.valid && o_out.ready;
    assign bit_len  = {{(LEN_W - COUNT_WIDTH){1'b0}}, r_count} << 3;

    // schedule: word 0 of the window is W[t]; the new word enters at word 15
    assign w_cur   = r_win[BLOCK_W-1 -: WORD_W];
    assign w_mix   = r_win[BLOCK_W-1-13*WORD_W -: WORD_W] ^ r_win[BLOCK_W-1-8*WORD_W -: WORD_W]
                   ^ r_win[BLOCK_W-1-2*WORD_W -: WORD_W] ^ w_cur;
    assign n_sched = {w_mix[WORD_W-2:0], w_mix[WORD_W-1]};

    // the shared round unit
    assign n_a = {r_a[WORD_W-6:0], r_a[WORD_W-1 -: 5]} + round_f(r_round, r_b, r_c, r_d)
               + r_e + w_cur + round_k(r_round);

    assign i_in.ready        = (r_state == ST_IDLE);
    assign o_out.valid       = (r_state == ST_OUT);
    assign o_out.digest_word = r_chain[r_idx];
    assign o_out.word_index  = r_idx;
    assign o_out.last        = (r_idx == LAST_IDX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_round     <= '0;
            r_idx       <= '0;
            r_finishing <= 1'b0;
            r_final     <= 1'b0;
            for (int i = 0; i < NUM_WORDS; i++) begin
                r_chain[i] <= IV[i];
            end
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_win   <= {r_win[BLOCK_W-BYTE_W-1:0],
                                    (i_in.op == OP_FINISH) ? PAD_MARK : i_in.data_byte};
                        r_count <= r_count + 1'b1;
                        if (i_in.op == OP_FINISH) begin
                            r_len       <= bit_len;
                            r_finishing <= 1'b1;
                        end
                        if (ofs == OFS_LAST) begin
                            {r_a, r_b, r_c, r_d, r_e} <= {r_chain[0], r_chain[1],
                                                          r_chain[2], r_chain[3], r_chain[4]};
                            r_state <= ST_ROUND;
                        end else if (i_in.op == OP_FINISH) begin
                            r_state <= ST_PAD;
                        end
                    end
                end
                ST_PAD: begin
                    if (ofs == OFS_LEN) begin
                        r_state <= ST_LEN;
                    end else begin
                        r_win   <= {r_win[BLOCK_W-BYTE_W-1:0], PAD_ZERO};
                        r_count <= r_count + 1'b1;
                        if (ofs == OFS_LAST) begin
                            {r_a, r_b, r_c, r_d, r_e} <= {r_chain[0], r_chain[1],
                                                          r_chain[2], r_chain[3], r_chain[4]};
                            r_state <= ST_ROUND;
                        end
                    end
                end
                ST_LEN: begin
                    r_win   <= {r_win[BLOCK_W-BYTE_W-1:0], r_len[LEN_W-1 -: BYTE_W]};
                    r_len   <= r_len << BYTE_W;
                    r_count <= r_count + 1'b1;
                    if (ofs == OFS_LAST) begin
                        {r_a, r_b, r_c, r_d, r_e} <= {r_chain[0], r_chain[1],
                                                      r_chain[2], r_chain[3], r_chain[4]};
                        r_final <= 1'b1;
                        r_state <= ST_ROUND;
                    end
                end
                ST_ROUND: begin
                    r_win <= {r_win[BLOCK_W-WORD_W-1:0], n_sched};
                    r_e   <= r_d;
                    r_d   <= r_c;
                    r_c   <= {r_b[1:0], r_b[WORD_W-1:2]};
                    r_b   <= r_a;
                    r_a   <= n_a;
                    if (r_round == LAST_ROUND) begin
                        r_round <= '0;
                        r_state <= ST_FOLD;
                    end else begin
                        r_round <= r_round + 1'b1;
                    end
                end
                ST_FOLD: begin
                    r_chain[0] <= r_chain[0] + r_a;
                    r_chain[1] <= r_chain[1] + r_b;
                    r_chain[2] <= r_chain[2] + r_c;
                    r_chain[3] <= r_chain[3] + r_d;
                    r_chain[4] <= r_chain[4] + r_e;
                    priority if (r_final) begin
                        r_idx   <= '0;
                        r_state <= ST_OUT;
                    end else if (r_finishing) begin
                        r_state <= ST_PAD;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_OUT: begin
                    if (out_fire) begin
                        if (r_idx == LAST_IDX) begin
                            for (int i = 0; i < NUM_WORDS; i++) begin
                                r_chain[i] <= IV[i];
                            end
                            r_count     <= '0;
                            r_finishing <= 1'b0;
                            r_final     <= 1'b0;
                            r_idx       <= '0;
                            r_state     <= ST_IDLE;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // ---- assertions ----
    // a byte that fills a block must start a compression
    `ASSERT_NEXT(a_full_block_busy, i_clk, i_rst_n, in_fire && i_in.op == OP_ABSORB && ofs == OFS_LAST, r_state == ST_ROUND)
    // after the last digest word the next message starts from scratch
    `ASSERT_NEXT(a_restart, i_clk, i_rst_n, out_fire && o_out.last, r_count == '0 && r_chain[0] == IV[0] && !r_final)
    // no input taken while digest words are pending
    `ASSERT_IMPLY(a_out_excl, i_clk, i_rst_n, o_out.valid, !i_in.ready)
    // digest is only emitted for a finished message
    `ASSERT_IMPLY(a_out_final, i_clk, i_rst_n, o_out.valid, r_final && r_finishing)

endmodule

@@ sim/tb_sha1_hash_engine.sv @@
// ----------------------------------------------------------------------------
// tb_sha1_hash_engine
// Self-checking bench: byte-stream messages in, five-word SHA-1 digests out.
// ----------------------------------------------------------------------------
// A scoreboard class keeps its own SHA-1 state (chain words, block buffer,
// byte count). Every accepted input transaction updates that state, and every
// finish queues the five digest words it must produce. The output monitor
// pops the oldest queued word and compares word, index and last flag.
// Stimulus: a directed group (empty message, byte extremes, "abc",
// back-to-back finishes), then random messages, mostly short, with some near
// the one-block / two-block padding boundary and a few multi-block ones.
// ----------------------------------------------------------------------------
module tb_sha1_hash_engine;
    timeunit 1ns;
    timeprecision 1ps;

    import sha1_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 12;
    localparam int LONG_HOLD    = 400;       // receiver hold-off, in cycles
    localparam int DRAIN_CYCLES = 50;
    localparam int LIMIT_CYCLES = 400_000;
    localparam int RAND_ITEMS   = 150;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [IDX_W-1:0]  idx;
        logic              last;
    } t_digest_word;

    // ------------------------------------------------------------------------
    // Scoreboard: SHA-1 state of the message in flight plus the digest words
    // still owed by the block.
    // ------------------------------------------------------------------------
    class digest_scoreboard;
        logic [WORD_W-1:0] chain [NUM_WORDS];
        logic [BYTE_W-1:0] blk [64];
        logic [COUNT_WIDTH-1:0] byte_cnt;
        t_digest_word      words_due [$];
        int                errors;
        int                words_checked;
        int                blocks_folded;
        int                two_block_finishes;
        int                messages;

        function new();
            errors             = 0;
            words_checked      = 0;
            blocks_folded      = 0;
            two_block_finishes = 0;
            messages           = 0;
            foreach (blk[i]) blk[i] = '0;
            restart();
        endfunction

        function void restart();
            chain[0] = 32'h67452301;
            chain[1] = 32'hEFCDAB89;
            chain[2] = 32'h98BADCFE;
            chain[3] = 32'h10325476;
            chain[4] = 32'hC3D2E1F0;
            byte_cnt = '0;
        endfunction

        // 80-round compression of blk into chain
        function void fold_block();
            logic [WORD_W-1:0] w [16];
            logic [WORD_W-1:0] a, b, c, d, e, f, k, wt, sum;
            for (int t = 0; t < 16; t++)
                w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
            a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
            for (int t = 0; t < 80; t++) begin
                if (t < 16) begin
                    wt = w[t];
                end else begin
                    wt = w[(t-3) & 15] ^ w[(t-8) & 15] ^ w[(t-14) & 15] ^ w[t & 15];
                    wt = {wt[30:0], wt[31]};
                    w[t & 15] = wt;
                end
                if (t < 20) begin
                    f = (b & c) | (~b & d);
                    k = 32'h5A827999;
                end else if (t < 40) begin
                    f = b ^ c ^ d;
                    k = 32'h6ED9EBA1;
                end else if (t < 60) begin
                    f = (b & c) | (b & d) | (c & d);
                    k = 32'h8F1BBCDC;
                end else begin
                    f = b ^ c ^ d;
                    k = 32'hCA62C1D6;
                end
                sum = {a[26:0], a[31:27]} + f + e + wt + k;
                e = d;
                d = c;
                c = {b[1:0], b[31:2]};
                b = a;
                a = sum;
            end
            chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
            blocks_folded++;
        endfunction

        function void note_input(t_op op, logic [BYTE_W-1:0] data);
            int                 ofs;
            logic [LEN_W-1:0]   bit_len;
            t_digest_word       dw;
            ofs = int'(byte_cnt[5:0]);
            if (op == OP_ABSORB) begin
                blk[ofs] = data;
                byte_cnt = byte_cnt + 1'b1;
                if (ofs == 63) fold_block();
            end else begin
                bit_len = {byte_cnt, 3'b000};
                blk[ofs] = 8'h80;
                for (int i = ofs + 1; i < 64; i++) blk[i] = '0;
                // no room for the length field: pad out a whole extra block
                if (ofs >= 56) begin
                    fold_block();
                    foreach (blk[i]) blk[i] = '0;
                    two_block_finishes++;
                end
                for (int i = 0; i < 8; i++) blk[56+i] = bit_len[63-8*i -: 8];
                fold_block();
                for (int i = 0; i < NUM_WORDS; i++) begin
                    dw.word = chain[i];
                    dw.idx  = IDX_W'(i);
                    dw.last = (i == NUM_WORDS - 1);
                    words_due.push_back(dw);
                end
                messages++;
                restart();
            end
        endfunction

        task report(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
            $display("[%0t] MISMATCH %s: got %h, want %h", $realtime, what, got, want);
            errors++;
        endtask

        task check_word(logic [WORD_W-1:0] word, logic [IDX_W-1:0] idx, logic last);
            t_digest_word want;
            if (words_due.size() == 0) begin
                report("digest word with none outstanding", word, '0);
            end else begin
                want = words_due.pop_front();
                if (word !== want.word) report("digest_word", word, want.word);
                if (idx !== want.idx)   report("word_index", WORD_W'(idx), WORD_W'(want.idx));
                if (last !== want.last) report("last", WORD_W'(last), WORD_W'(want.last));
            end
            words_checked++;
        endtask

        function int pending();
            return words_due.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels, DUT
    // ------------------------------------------------------------------------
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    sha1_in_if  in_ch ();
    sha1_out_if out_ch ();

    sha1_hash_engine dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    digest_scoreboard sb = new();

    // idle percentages, switched by the stimulus as the run moves on
    int  send_idle_pct = 38;
    int  recv_idle_pct = 52;
    bit  hold_armed    = 1'b0;
    bit  hold_done     = 1'b0;
    int  items_sent    = 0;
    int  rand_items    = 0;

    // all DUT inputs known from time zero
    initial begin
        in_ch.valid     = 1'b0;
        in_ch.op        = OP_ABSORB;
        in_ch.data_byte = '0;
        out_ch.ready    = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Sender: one transaction per call. Inputs move on the falling edge only;
    // acceptance is judged at the rising edge from pre-edge values.
    // ------------------------------------------------------------------------
    task automatic send_item(t_op op, logic [BYTE_W-1:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid     = 1'b0;
            in_ch.op        = t_op'($urandom_range(1));
            in_ch.data_byte = BYTE_W'($urandom);
            @(negedge i_clk);
        end
        in_ch.valid     = 1'b1;
        in_ch.op        = op;
        in_ch.data_byte = data;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_input(op, data);
        items_sent++;
        @(negedge i_clk);
    endtask

    // random message: absorbs of random bytes, then a finish
    task automatic send_message(int len);
        logic [BYTE_W-1:0] b;
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(7))
                0:       b = 8'h00;
                1:       b = 8'hFF;
                default: b = BYTE_W'($urandom);
            endcase
            send_item(OP_ABSORB, b);
            rand_items++;
        end
        // data_byte is don't-care on a finish; drive it random anyway
        send_item(OP_FINISH, BYTE_W'($urandom));
        rand_items++;
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random ready, plus one long hold-off so the digest backs up
    // and the input side stalls while the sender keeps offering.
    // ------------------------------------------------------------------------
    initial begin
        int stall_cycles;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_armed && !hold_done && out_ch.valid) begin
                out_ch.ready = 1'b0;
                for (stall_cycles = 0; stall_cycles < LONG_HOLD; stall_cycles++)
                    @(negedge i_clk);
                hold_done = 1'b1;
            end
            out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // output monitor: one check per accepted digest-word transaction
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_word(out_ch.digest_word, out_ch.word_index, out_ch.last);
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int len;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: empty message with an all-ones don't-care byte
        send_item(OP_FINISH, 8'hFF);
        // byte extremes and alternating patterns
        send_item(OP_ABSORB, 8'h00);
        send_item(OP_ABSORB, 8'hFF);
        send_item(OP_ABSORB, 8'hA5);
        send_item(OP_ABSORB, 8'h5A);
        send_item(OP_FINISH, 8'h00);
        // "abc"
        send_item(OP_ABSORB, 8'h61);
        send_item(OP_ABSORB, 8'h62);
        send_item(OP_ABSORB, 8'h63);
        send_item(OP_FINISH, 8'h55);
        // finish right after finish: second one hashes the empty message
        send_item(OP_ABSORB, 8'h80);
        send_item(OP_FINISH, 8'hAA);
        send_item(OP_FINISH, 8'h00);
        send_item(OP_ABSORB, 8'h01);
        send_item(OP_FINISH, 8'hFF);

        // random part; arm the long output hold-off
        hold_armed = 1'b1;
        while (items_sent < RAND_ITEMS) begin
            // idle phases: receiver-heavy, then sender-heavy, then none
            if (rand_items < RAND_ITEMS / 3) begin
                send_idle_pct = 38; recv_idle_pct = 52;
            end else if (rand_items < 2 * RAND_ITEMS / 3) begin
                send_idle_pct = 52; recv_idle_pct = 38;
            end else begin
                send_idle_pct = 0;  recv_idle_pct = 0;
            end
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: len = $urandom_range(12);
                6, 7:             len = $urandom_range(66, 54);   // padding boundary
                8:                len = $urandom_range(130, 112); // two-block / three-block padding boundary
                default:          len = 0;
            endcase
            send_message(len);
        end
        in_ch.valid = 1'b0;

        // drain: every expected digest word, then a quiet tail
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report("digest words never delivered", WORD_W'(sb.pending()), '0);

        $display("Run covered %0d input transactions, %0d messages, %0d blocks compressed",
                 items_sent, sb.messages, sb.blocks_folded);
        $display("%0d digest words checked, %0d finishes needed an extra padding block",
                 sb.words_checked, sb.two_block_finishes);
        if (sb.errors == 0) begin
            $display("tb_sha1_hash_engine OK");
        end else begin
            $display("tb_sha1_hash_engine NOT OK");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(LIMIT_CYCLES * 2 * HALF_PERIOD);
        $display("Timeout after %0d cycles", LIMIT_CYCLES);
        $display("tb_sha1_hash_engine NOT OK");
        $finish;
    end

endmodule
